[rtl/pcsd_pkg.sv]
// Package: item types, command codes, duty table and sweep helpers for the pulse channel.
`timescale 1ns / 1ps

package pcsd_pkg;

  // Command codes carried by an input transaction
  typedef enum logic [1:0] {
    CMD_SWEEP_WRITE   = 2'd0,
    CMD_PERIOD_LOAD   = 2'd1,
    CMD_SWEEP_CLOCK   = 2'd2,
    CMD_SAMPLE_UPDATE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data;
    logic [11:0] period_value;
    logic        sample_enable;
    logic [3:0]  volume;
    logic [1:0]  duty_mode;
    logic [2:0]  duty_step;
  } in_item_t;

  typedef struct packed {
    logic [11:0] period;
    logic [3:0]  sample;
    logic        overflow_carry;
    logic        muted;
  } out_item_t;

  localparam logic [11:0] PERIOD_MAX       = 12'd4095;
  localparam logic [11:0] SWEEP_MIN_PERIOD = 12'd7;

  // Sweep byte layout
  localparam int unsigned SWEEP_NEGATE_BIT = 3;
  localparam int unsigned SWEEP_ENABLE_BIT = 7;

  // Duty rows, bit n is step n of the sequence
  localparam logic [7:0] DUTY_ROWS [4] = '{
    8'b0000_0010,
    8'b0000_0110,
    8'b0001_1110,
    8'b1111_1001
  };

  // Add-mode target above the period range
  function automatic logic mute_check(input logic [11:0] period, input logic [2:0] shift,
                                      input logic negate);
    logic [12:0] target;
    target = {1'b0, period} + {1'b0, period >> shift};
    return !negate && target[12];
  endfunction

endpackage

[rtl/pulse_channel_sweep_and_duty.sv]
// Sweep unit and output stage of a pulse sound channel.
//
// Input channel in_valid/in_ready/in_data carries one command per transaction:
// sweep register write, period load, sweep clock or sample update. Each
// transaction yields exactly one result transaction on out_valid/out_ready/
// out_data with the period, held sample level, carry flag and mute status as
// they stand after the command.
// The cfg channel writes the channel number (changes the subtract-mode sweep
// offset); it is always ready and should only be written while idle.
// An accepted transaction is latched in the input register and applied to the
// channel state when the result register advances; its result is then valid.
// Throughput: one transaction per clock without a stall; the state update is
// a single shift, add and compare on 12-bit values between the two registers.
// Reset (rst, synchronous) clears the period, sweep settings, divider,
// carry and sample level, and empties both stages.
// When the receiver stalls, the result register holds, the input register
// still takes one more transaction, and then in_ready drops.
`timescale 1ns / 1ps

module pulse_channel_sweep_and_duty
  import pcsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  // Input stage
  logic     stage_valid;
  in_item_t stage_item;

  // Channel state
  logic        channel_number;
  logic [11:0] timer_period, timer_period_next;
  logic [2:0]  shift_amount, shift_amount_next;
  logic        negate_mode, negate_mode_next;
  logic [3:0]  divider_rate, divider_rate_next;
  logic        sweep_on, sweep_on_next;
  logic [3:0]  divider_count, divider_count_next;
  logic        carry_flag, carry_flag_next;
  logic        reload_pending, reload_pending_next;
  logic [3:0]  sample_level, sample_level_next;

  logic        advance;
  logic        apply;
  logic [11:0] delta;
  logic [12:0] sweep_sum;
  logic [12:0] sweep_diff;
  logic [7:0]  duty_row;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance || !stage_valid;
  assign apply     = stage_valid && advance;

  // Capture channel number
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_number <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      channel_number <= cfg_data;
    end
  end

  // Latch accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_data;
    end
  end

  // Sweep arithmetic on the current period
  assign delta      = timer_period >> shift_amount;
  assign sweep_sum  = {1'b0, timer_period} + {1'b0, delta};
  assign sweep_diff = {1'b0, timer_period} - {1'b0, delta} + {12'd0, channel_number};
  assign duty_row   = DUTY_ROWS[stage_item.duty_mode];

  // Apply the command to the channel state
  always_comb begin
    timer_period_next   = timer_period;
    shift_amount_next   = shift_amount;
    negate_mode_next    = negate_mode;
    divider_rate_next   = divider_rate;
    sweep_on_next       = sweep_on;
    divider_count_next  = divider_count;
    carry_flag_next     = carry_flag;
    reload_pending_next = reload_pending;
    sample_level_next   = sample_level;
    unique case (stage_item.cmd)
      CMD_SWEEP_WRITE: begin
        shift_amount_next   = stage_item.data[2:0];
        negate_mode_next    = stage_item.data[SWEEP_NEGATE_BIT];
        divider_rate_next   = {1'b0, stage_item.data[6:4]} + 4'd1;
        sweep_on_next       = stage_item.data[SWEEP_ENABLE_BIT];
        reload_pending_next = 1'b1;
      end
      CMD_PERIOD_LOAD: begin
        timer_period_next = stage_item.period_value;
      end
      CMD_SWEEP_CLOCK: begin
        if (divider_count <= 4'd1) begin
          divider_count_next = divider_rate;
          if (sweep_on && (shift_amount != 3'd0) && (timer_period > SWEEP_MIN_PERIOD)) begin
            if (!negate_mode) begin
              carry_flag_next   = sweep_sum[12];
              timer_period_next = sweep_sum[12] ? PERIOD_MAX : sweep_sum[11:0];
            end else begin
              carry_flag_next   = 1'b0;
              timer_period_next = sweep_diff[12] ? PERIOD_MAX : sweep_diff[11:0];
            end
          end
        end else begin
          divider_count_next = divider_count - 4'd1;
        end
        // Pending reload wins over the expiry check
        if (reload_pending) begin
          reload_pending_next = 1'b0;
          divider_count_next  = divider_rate;
        end
      end
      CMD_SAMPLE_UPDATE: begin
        if (!stage_item.sample_enable || mute_check(timer_period, shift_amount, negate_mode)) begin
          sample_level_next = 4'd0;
        end else begin
          sample_level_next = duty_row[stage_item.duty_step] ? stage_item.volume : 4'd0;
        end
      end
      default: begin
        sample_level_next = sample_level;
      end
    endcase
  end

  // Advance channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period   <= '0;
      shift_amount   <= '0;
      negate_mode    <= 1'b0;
      divider_rate   <= '0;
      sweep_on       <= 1'b0;
      divider_count  <= '0;
      carry_flag     <= 1'b0;
      reload_pending <= 1'b0;
      sample_level   <= '0;
    end else if (apply) begin
      timer_period   <= timer_period_next;
      shift_amount   <= shift_amount_next;
      negate_mode    <= negate_mode_next;
      divider_rate   <= divider_rate_next;
      sweep_on       <= sweep_on_next;
      divider_count  <= divider_count_next;
      carry_flag     <= carry_flag_next;
      reload_pending <= reload_pending_next;
      sample_level   <= sample_level_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_data.period         <= timer_period_next;
      out_data.sample         <= sample_level_next;
      out_data.overflow_carry <= carry_flag_next;
      out_data.muted          <= mute_check(timer_period_next, shift_amount_next,
                                            negate_mode_next);
    end
  end

endmodule

[rtl/pcsd_checker.sv]
// Checker: port-level assertions for the pulse channel, bound to the top level.
`timescale 1ns / 1ps

module pcsd_checker
  import pcsd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Add-mode overflow needs a period in the upper half of the range
  a_mute_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.muted |-> out_data.period[11])
    else $error("muted with a period below half range");

endmodule

bind pulse_channel_sweep_and_duty pcsd_checker u_pcsd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/pulse_channel_sweep_and_duty_test.sv]
// Self-checking testbench for the pulse channel sweep unit and duty output stage.
`timescale 1ns / 1ps

module pulse_channel_sweep_and_duty_test;
  import pcsd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 120;

  // Duty waveforms, leftmost bit is step 0
  localparam bit [0:7] DUTY_WAVE [4] = '{
    8'b01000000,
    8'b01100000,
    8'b01111000,
    8'b10011111
  };

  // Tracks the channel state and queues the result each command should produce
  class sweep_duty_predictor;
    out_item_t   expected_outputs[$];
    int          errors;
    logic        channel_r;
    logic [11:0] period_r;
    logic [2:0]  shift_r;
    logic        negate_r;
    logic [3:0]  rate_r;
    logic        sweep_on_r;
    logic [3:0]  count_r;
    logic        carry_r;
    logic        reload_r;
    logic [3:0]  level_r;

    function new();
      errors = 0;
      channel_r = 1'b0;
      period_r = '0;
      shift_r = '0;
      negate_r = 1'b0;
      rate_r = '0;
      sweep_on_r = 1'b0;
      count_r = '0;
      carry_r = 1'b0;
      reload_r = 1'b0;
      level_r = '0;
    endfunction

    function void set_channel(logic value);
      channel_r = value;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // Add-mode target leaves the 12-bit period range
    function logic muted_now();
      logic [12:0] target;
      target = {1'b0, period_r} + {1'b0, period_r >> shift_r};
      return !negate_r && (target > {1'b0, PERIOD_MAX});
    endfunction

    function void note_input(in_item_t item);
      out_item_t   expected;
      logic [12:0] next_period;
      logic [11:0] delta;
      case (item.cmd)
        CMD_SWEEP_WRITE: begin
          shift_r = item.data[2:0];
          negate_r = item.data[SWEEP_NEGATE_BIT];
          rate_r = {1'b0, item.data[6:4]} + 4'd1;
          sweep_on_r = item.data[SWEEP_ENABLE_BIT];
          reload_r = 1'b1;
        end
        CMD_PERIOD_LOAD: begin
          period_r = item.period_value;
        end
        CMD_SWEEP_CLOCK: begin
          // Divider expires at 0 or 1, then the sweep may adjust the period
          if (count_r <= 4'd1) begin
            count_r = rate_r;
            if (sweep_on_r && shift_r != 3'd0 && period_r > SWEEP_MIN_PERIOD) begin
              delta = period_r >> shift_r;
              carry_r = 1'b0;
              if (!negate_r) begin
                next_period = {1'b0, period_r} + {1'b0, delta};
                if (next_period > {1'b0, PERIOD_MAX}) begin
                  next_period = {1'b0, PERIOD_MAX};
                  carry_r = 1'b1;
                end
              end else begin
                next_period = {1'b0, period_r} - {1'b0, delta} + {12'd0, channel_r};
                if (next_period > {1'b0, PERIOD_MAX}) begin
                  next_period = {1'b0, PERIOD_MAX};
                end
              end
              period_r = next_period[11:0];
            end
          end else begin
            count_r = count_r - 4'd1;
          end
          // A pending reload wins over the expiry result
          if (reload_r) begin
            reload_r = 1'b0;
            count_r = rate_r;
          end
        end
        CMD_SAMPLE_UPDATE: begin
          if (!item.sample_enable || muted_now()) begin
            level_r = 4'd0;
          end else begin
            level_r = DUTY_WAVE[item.duty_mode][item.duty_step] ? item.volume : 4'd0;
          end
        end
      endcase
      expected.period = period_r;
      expected.sample = level_r;
      expected.overflow_carry = carry_r;
      expected.muted = muted_now();
      expected_outputs.push_back(expected);
    endfunction

    function void check_result(out_item_t got);
      out_item_t expected;
      if (expected_outputs.size() == 0) begin
        $error("result transaction with nothing expected: period %0d sample %0d",
               got.period, got.sample);
        errors++;
        return;
      end
      expected = expected_outputs.pop_front();
      if (got.period !== expected.period) begin
        $error("period: expected %0d, got %0d", expected.period, got.period);
        errors++;
      end
      if (got.sample !== expected.sample) begin
        $error("sample: expected %0d, got %0d", expected.sample, got.sample);
        errors++;
      end
      if (got.overflow_carry !== expected.overflow_carry) begin
        $error("overflow_carry: expected %0b, got %0b", expected.overflow_carry,
               got.overflow_carry);
        errors++;
      end
      if (got.muted !== expected.muted) begin
        $error("muted: expected %0b, got %0b", expected.muted, got.muted);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  sweep_duty_predictor predictor;

  int stalled_cycles = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  pulse_channel_sweep_and_duty u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Record accepted commands, check results, and watch for a hung channel
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predictor.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        predictor.check_result(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT) begin
          $display("pulse_channel_sweep_and_duty_test: errors");
          $finish;
        end
      end
    end
  end

  // Result side backpressure: random patterns, plus a long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left = $urandom_range(80, 20);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3) != 0);
        2: out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  function automatic in_item_t build_cmd(cmd_t c, logic [7:0] d, logic [11:0] p, logic en,
                                         logic [3:0] vol, logic [1:0] mode, logic [2:0] step);
    in_item_t item;
    item.cmd = c;
    item.data = d;
    item.period_value = p;
    item.sample_enable = en;
    item.volume = vol;
    item.duty_mode = mode;
    item.duty_step = step;
    return item;
  endfunction

  // Mostly sweep clocks and sample updates so the divider gets exercised
  function automatic in_item_t random_cmd();
    in_item_t    item;
    int unsigned pick;
    item = in_item_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      item.cmd = CMD_SWEEP_WRITE;
      if ($urandom_range(3) != 0) begin
        item.data[SWEEP_ENABLE_BIT] = 1'b1;
      end
    end else if (pick < 25) begin
      item.cmd = CMD_PERIOD_LOAD;
      if ($urandom_range(3) == 0) begin
        item.period_value = 12'($urandom_range(15));
      end
    end else if (pick < 70) begin
      item.cmd = CMD_SWEEP_CLOCK;
    end else begin
      item.cmd = CMD_SAMPLE_UPDATE;
      if ($urandom_range(4) != 0) begin
        item.sample_enable = 1'b1;
      end
    end
    return item;
  endfunction

  // Present one command and hold it until the block takes it
  task automatic offer_cmd(input in_item_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send random commands in bursts, each after an idle gap that may be empty
  task automatic send_random(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(5) == 0) ? $urandom_range(20, 8) : $urandom_range(3);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      end
      offer_cmd(random_cmd());
      burst_left--;
    end
  endtask

  // Stop offering and let every outstanding result come back; the queue is
  // checked only after the monitor has sampled, so the last accepted command is on it
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (predictor.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_channel(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    predictor.set_channel(value);
  endtask

  initial begin
    predictor = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: sample levels, mute, add saturation, divider expiry and reload
    offer_cmd(build_cmd(CMD_SAMPLE_UPDATE, 8'h00, 12'd0, 1'b1, 4'd15, 2'd3, 3'd0));
    offer_cmd(build_cmd(CMD_SAMPLE_UPDATE, 8'h00, 12'd0, 1'b0, 4'd15, 2'd3, 3'd0));
    offer_cmd(build_cmd(CMD_PERIOD_LOAD, 8'h00, 12'd4095, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SAMPLE_UPDATE, 8'h00, 12'd0, 1'b1, 4'd15, 2'd1, 3'd1));
    offer_cmd(build_cmd(CMD_SWEEP_WRITE, 8'h81, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_PERIOD_LOAD, 8'h00, 12'd1024, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SAMPLE_UPDATE, 8'h00, 12'd0, 1'b1, 4'd15, 2'd1, 3'd2));
    offer_cmd(build_cmd(CMD_SWEEP_WRITE, 8'hFF, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    // Period at the minimum while the divider still counts, then one above it, which sweeps on expiry
    offer_cmd(build_cmd(CMD_PERIOD_LOAD, 8'h00, 12'd7, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_WRITE, 8'h91, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_PERIOD_LOAD, 8'h00, 12'd8, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    // Zero shift still mutes once twice the period leaves the range
    offer_cmd(build_cmd(CMD_SWEEP_WRITE, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_PERIOD_LOAD, 8'h00, 12'd2048, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SAMPLE_UPDATE, 8'h00, 12'd0, 1'b1, 4'd7, 2'd2, 3'd3));
    offer_cmd(build_cmd(CMD_PERIOD_LOAD, 8'h00, 12'd2047, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SAMPLE_UPDATE, 8'h00, 12'd0, 1'b1, 4'd8, 2'd2, 3'd4));

    send_random(150);
    wait_for_results();

    // Second channel: subtract path gains one
    write_channel(1'b1);
    offer_cmd(build_cmd(CMD_PERIOD_LOAD, 8'h00, 12'd8, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_WRITE, 8'h89, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));
    offer_cmd(build_cmd(CMD_SWEEP_CLOCK, 8'h00, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0));

    // Hold results off for a long stretch while commands keep coming
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 30; i++) begin
      offer_cmd(random_cmd());
    end
    send_random(120);
    wait_for_results();

    write_channel(1'b0);
    send_random(150);
    wait_for_results();

    write_channel(1'b1);
    send_random(150);
    wait_for_results();

    if (predictor.errors == 0) begin
      $display("pulse_channel_sweep_and_duty_test: clean");
    end else begin
      $display("pulse_channel_sweep_and_duty_test: errors");
    end
    $finish;
  end

endmodule
